// File: sv/bpdt_pkg.sv
package bpdt_pkg;

  localparam int unsigned SLOTS  = 4096;
  localparam int unsigned PROBES = 4;

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(PROBES + 1);
  localparam int unsigned PID_W  = 22;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned SLOT_W = PID_W + TIME_W;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    ACT_LOOKUP    = 2'd0,
    ACT_MARK      = 2'd1,
    ACT_CLEAR_ONE = 2'd2,
    ACT_CLEAR_ALL = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [PID_W-1:0]    process_id;
    logic [TIME_W-1:0]   start_time;
  } req_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } rsp_t;

endpackage

// File: sv/bpdt_ram.sv
module bpdt_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 86
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bpdt_hash.sv
module bpdt_hash
  import bpdt_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [PID_W-1:0] process_id_i,
  output logic [IDX_W-1:0] home_o
);

  // Only the low product bits select the home slot, so the wrapping
  // 32-bit product is all that is needed.
  logic [31:0]      prod;
  logic [IDX_W-1:0] home_q;

  assign prod = 32'(process_id_i) * HASH_MULT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      home_q <= prod[IDX_W-1:0];
    end
  end

  assign home_o = home_q;

endmodule

// File: sv/bounded_probe_dedup_table.sv
// Deduplication table of (process id, start time) pairs in a 4096-slot memory with
// linear probing over up to four slots from a multiplicative-hash home slot. A
// transaction is taken at a clock edge where start is high and busy is low; its
// single result appears on rsp_o for exactly one cycle with rsp_valid_o high and
// cannot be held off, so the receiver must take it in that cycle. Lookup, mark and
// clear-one run through the hash multiplier, then one memory read per probe through
// the single read port, with registered read data; a decision on the first probe is
// the fast case. The result strobe comes in the first cycle with busy low again. A
// lookup or mark with a zero start time skips probing. Clear-all sweeps the memory
// one slot per cycle through the single write port. After reset the same sweep runs
// with busy high before the first transaction can be taken.
module bounded_probe_dedup_table
  import bpdt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_SWEEP
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic [CNT_W-1:0] issue_q;
  logic [CNT_W-1:0] chk_q;
  logic             rvalid_q;
  logic [IDX_W-1:0] sweep_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q;

  logic              accept;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  probe_addr;
  logic [IDX_W-1:0]  chk_addr;
  logic              re;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [SLOT_W-1:0] wdata;
  logic [SLOT_W-1:0] rdata;
  logic [PID_W-1:0]  slot_pid;
  logic [TIME_W-1:0] slot_time;
  logic              id_eq;
  logic              pair_eq;
  logic              slot_empty;
  logic              last_probe;
  logic              finish;
  rsp_t              fin_rsp;
  logic              sweep_done;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // The hash unit latches the home slot in the cycle after acceptance.
  bpdt_hash u_hash (
    .clk_i        (clk_i),
    .en_i         (state_q == ST_HASH),
    .process_id_i (req_q.process_id),
    .home_o       (home)
  );

  bpdt_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (probe_addr),
    .rdata_o (rdata)
  );

  // Probe addresses wrap naturally at the end of the store.
  assign probe_addr = home + IDX_W'(issue_q);
  assign chk_addr   = home + IDX_W'(chk_q);
  assign re         = (state_q == ST_PROBE) && (issue_q < CNT_W'(PROBES));

  assign slot_pid   = rdata[SLOT_W-1:TIME_W];
  assign slot_time  = rdata[TIME_W-1:0];
  assign id_eq      = (slot_pid == req_q.process_id);
  assign pair_eq    = id_eq && (slot_time == req_q.start_time);
  assign slot_empty = (slot_pid == '0);
  assign last_probe = (chk_q == CNT_W'(PROBES - 1));
  assign sweep_done = (sweep_q == {IDX_W{1'b1}});

  // Decision on the slot whose read data has just arrived. Probes are judged
  // strictly in order, so the first qualifying slot wins, as in a software scan.
  always_comb begin
    finish  = 1'b0;
    fin_rsp = '0;
    we      = 1'b0;
    waddr   = chk_addr;
    wdata   = '0;
    if ((state_q == ST_INIT) || (state_q == ST_SWEEP)) begin
      we    = 1'b1;
      waddr = sweep_q;
    end else if ((state_q == ST_PROBE) && rvalid_q) begin
      case (req_q.action)
        ACT_LOOKUP: begin
          if (pair_eq) begin
            finish      = 1'b1;
            fin_rsp.hit = 1'b1;
          end else if (last_probe) begin
            finish = 1'b1;
          end
        end
        ACT_MARK: begin
          if (pair_eq) begin
            finish      = 1'b1;
            fin_rsp.hit = 1'b1;
          end else if (slot_empty) begin
            finish = 1'b1;
            we     = 1'b1;
            wdata  = {req_q.process_id, req_q.start_time};
          end else if (last_probe) begin
            // Every probed slot is taken: the home slot is overwritten.
            finish          = 1'b1;
            fin_rsp.evicted = 1'b1;
            we              = 1'b1;
            waddr           = home;
            wdata           = {req_q.process_id, req_q.start_time};
          end
        end
        ACT_CLEAR_ONE: begin
          if (id_eq) begin
            finish      = 1'b1;
            fin_rsp.hit = 1'b1;
            we          = 1'b1;
          end else if (last_probe) begin
            finish = 1'b1;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  // Request payload holds for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      issue_q     <= '0;
      chk_q       <= '0;
      rvalid_q    <= 1'b0;
      sweep_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      rvalid_q    <= re;
      if (re) begin
        chk_q   <= issue_q;
        issue_q <= issue_q + CNT_W'(1);
      end
      case (state_q)
        ST_INIT: begin
          sweep_q <= sweep_q + IDX_W'(1);
          if (sweep_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_i.action == ACT_CLEAR_ALL) begin
              sweep_q <= '0;
              state_q <= ST_SWEEP;
            end else begin
              state_q <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          issue_q <= '0;
          // A zero start time can never hit and is never stored.
          if (((req_q.action == ACT_LOOKUP) || (req_q.action == ACT_MARK)) &&
              (req_q.start_time == '0)) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= '0;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (finish) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= fin_rsp;
            state_q     <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          sweep_q <= sweep_q + IDX_W'(1);
          if (sweep_done) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A result is only ever produced on the way back to idle.
  a_rsp_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction always leaves the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after acceptance");

  // Results never come back to back: each needs its own transaction.
  a_single_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("two results for one transaction");

  // An eviction only follows a failed search, so it never comes with a hit.
  a_evict_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("hit and eviction reported together");

endmodule

// File: tb/sv/bounded_probe_dedup_table_test.sv
module bounded_probe_dedup_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpdt_pkg::*;

  // The whole run, including the clearing sweep after reset and the clear-all
  // sweeps of the random part, fits several times over into this many cycles.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1925;
  // The final stretch of random traffic runs with start held high back to back.
  localparam int CALM_TAIL    = 300;
  // Cycles allowed after the last result before the verdict is printed.
  localparam int DRAIN_CYCLES = PROBES + 8;
  localparam int HOT_HOMES    = 6;
  localparam int HIGH_W       = PID_W - IDX_W;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  bounded_probe_dedup_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the slot store, updated at the clock edge where each
  // transaction is taken by the block.
  logic [PID_W-1:0]  shadow_pid  [SLOTS];
  logic [TIME_W-1:0] shadow_time [SLOTS];

  // Answers owed by the block, oldest first.
  rsp_t answers_due [$];
  rsp_t oldest_answer;
  int   errors      = 0;
  int   cycle_count = 0;

  // Low id bits that land on a few chosen home slots. Random ids are mostly
  // built on these so that probe chains fill up, overlap and wrap.
  logic [IDX_W-1:0] hot_low [HOT_HOMES];

  // Home slot: low index bits of the 32-bit product of the id and the
  // multiplicative hash constant.
  function automatic logic [IDX_W-1:0] home_of(input logic [PID_W-1:0] pid);
    logic [31:0] prod;
    prod = 32'(pid) * HASH_MULT;
    return prod[IDX_W-1:0];
  endfunction

  // Since the constant is odd, the home slot depends only on the low id bits
  // and every slot has exactly one such preimage; search for it.
  function automatic logic [IDX_W-1:0] low_id_for_home(input logic [IDX_W-1:0] home);
    for (int k = 0; k < SLOTS; k++) begin
      if (home_of(PID_W'(k)) == home) begin
        return IDX_W'(k);
      end
    end
    return '0;
  endfunction

  // Applies one transaction to the shadow store and returns the answer that
  // the block owes for it.
  function automatic rsp_t dedup_apply(input req_t item);
    rsp_t             answer;
    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] slot;
    bit               done;
    answer = '0;
    home   = home_of(item.process_id);
    done   = 1'b0;
    case (item.action)
      ACT_LOOKUP: begin
        // An unknown start time never matches anything.
        if (item.start_time != '0) begin
          for (int i = 0; i < PROBES && !done; i++) begin
            slot = home + IDX_W'(i);
            if (shadow_pid[slot] == item.process_id &&
                shadow_time[slot] == item.start_time) begin
              answer.hit = 1'b1;
              done       = 1'b1;
            end
          end
        end
      end
      ACT_MARK: begin
        if (item.start_time != '0) begin
          // The scan stops at an exact pair or at the first empty slot,
          // whichever comes first along the chain.
          for (int i = 0; i < PROBES && !done; i++) begin
            slot = home + IDX_W'(i);
            if (shadow_pid[slot] == item.process_id &&
                shadow_time[slot] == item.start_time) begin
              answer.hit = 1'b1;
              done       = 1'b1;
            end else if (shadow_pid[slot] == '0) begin
              shadow_pid[slot]  = item.process_id;
              shadow_time[slot] = item.start_time;
              done              = 1'b1;
            end
          end
          // A full chain loses whatever sits in the home slot.
          if (!done) begin
            shadow_pid[home]  = item.process_id;
            shadow_time[home] = item.start_time;
            answer.evicted    = 1'b1;
          end
        end
      end
      ACT_CLEAR_ONE: begin
        for (int i = 0; i < PROBES && !done; i++) begin
          slot = home + IDX_W'(i);
          if (shadow_pid[slot] == item.process_id) begin
            shadow_pid[slot]  = '0;
            shadow_time[slot] = '0;
            answer.hit        = 1'b1;
            done              = 1'b1;
          end
        end
      end
      ACT_CLEAR_ALL: begin
        for (int k = 0; k < SLOTS; k++) begin
          shadow_pid[k]  = '0;
          shadow_time[k] = '0;
        end
      end
      default: ;
    endcase
    return answer;
  endfunction

  function automatic req_t make_item(input action_e action, input logic [PID_W-1:0] pid,
                                     input logic [TIME_W-1:0] stime);
    req_t item;
    item.action     = action;
    item.process_id = pid;
    item.start_time = stime;
    return item;
  endfunction

  // Sends one transaction. Called right after a rising edge; start stays high
  // on return so that a following call keeps the stream back to back.
  task automatic issue(input req_t item);
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    answers_due.push_back(dedup_apply(item));
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  // Lookups, clears and marks against an empty store. A clear of id zero
  // finds the empty home slot and reports a hit.
  task automatic test_empty_table();
    issue(make_item(ACT_LOOKUP, '0, '0));
    issue(make_item(ACT_LOOKUP, PID_W'(5), TIME_W'(7)));
    issue(make_item(ACT_CLEAR_ONE, PID_W'(9), TIME_W'(7)));
    issue(make_item(ACT_MARK, PID_W'(3), '0));
    issue(make_item(ACT_CLEAR_ONE, '0, '1));
  endtask

  // Field extremes: the largest id with an all-ones start time, marked twice,
  // then looked up with and without a start time and cleared by id alone.
  task automatic test_mark_and_lookup();
    issue(make_item(ACT_MARK, '1, '1));
    issue(make_item(ACT_MARK, '1, '1));
    issue(make_item(ACT_LOOKUP, '1, '1));
    issue(make_item(ACT_LOOKUP, '1, '0));
    issue(make_item(ACT_CLEAR_ONE, '1, '0));
    issue(make_item(ACT_LOOKUP, '1, '1));
  endtask

  // Five ids share one home slot, so the fifth mark finds the chain full and
  // evicts the first. Clearing the middle of the chain opens a hole that the
  // next mark fills.
  task automatic test_probe_chain();
    logic [IDX_W-1:0] low;
    low = low_id_for_home(IDX_W'(100));
    for (int j = 0; j <= PROBES; j++) begin
      issue(make_item(ACT_MARK, {HIGH_W'(j), low}, TIME_W'(j + 1)));
    end
    issue(make_item(ACT_LOOKUP, {HIGH_W'(0), low}, TIME_W'(1)));
    issue(make_item(ACT_CLEAR_ONE, {HIGH_W'(2), low}, '0));
    issue(make_item(ACT_MARK, {HIGH_W'(0), low}, TIME_W'(1)));
  endtask

  // A chain from the last slot wraps to slot zero. Id zero then hashes to
  // slot zero, walks past the occupied slots and lands in the first empty
  // one, where a clear of id zero finds it again.
  task automatic test_wrap_and_zero_id();
    logic [IDX_W-1:0] low;
    low = low_id_for_home(IDX_W'(SLOTS - 1));
    for (int j = 0; j < 3; j++) begin
      issue(make_item(ACT_MARK, {HIGH_W'(j + 1), low}, TIME_W'(40 + j)));
    end
    issue(make_item(ACT_LOOKUP, {HIGH_W'(3), low}, TIME_W'(42)));
    issue(make_item(ACT_MARK, '0, TIME_W'(55)));
    issue(make_item(ACT_CLEAR_ONE, '0, '0));
  endtask

  // Clear-all empties everything marked so far and is followed by a lookup. The
  // sender then holds off until every answer is in before the random traffic starts.
  task automatic test_clear_all();
    issue(make_item(ACT_CLEAR_ALL, '1, '1));
    issue(make_item(ACT_LOOKUP, {HIGH_W'(0), low_id_for_home(IDX_W'(100))}, TIME_W'(2)));
    wait_for_quiet();
  endtask

  function automatic req_t random_item();
    req_t item;
    int   roll;
    roll = $urandom_range(0, 255);
    if (roll < 2) begin
      item.action = ACT_CLEAR_ALL;
    end else if (roll < 92) begin
      item.action = ACT_LOOKUP;
    end else if (roll < 194) begin
      item.action = ACT_MARK;
    end else begin
      item.action = ACT_CLEAR_ONE;
    end
    if ($urandom_range(0, 7) == 0) begin
      item.process_id = PID_W'($urandom);
    end else begin
      item.process_id = {HIGH_W'($urandom_range(0, 5)),
                         hot_low[$urandom_range(0, HOT_HOMES - 1)]};
    end
    // A small pool of start times makes exact pairs, and so hits, common.
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      item.start_time = '0;
    end else if (roll < 3) begin
      item.start_time = {$urandom, $urandom};
    end else begin
      item.start_time = TIME_W'($urandom_range(1, 3));
    end
    return item;
  endfunction

  // Random traffic over a handful of crowded home slots, four of them around the
  // wrap point and two close enough that their chains overlap. The sender
  // idles in bursts except in some windows and in the final stretch, and once
  // halfway through it waits until nothing is outstanding.
  task automatic test_random_traffic(input int count);
    int spot;
    spot = $urandom_range(2, SLOTS - 6);
    hot_low[0] = low_id_for_home(IDX_W'(SLOTS - 2));
    hot_low[1] = low_id_for_home(IDX_W'(SLOTS - 1));
    hot_low[2] = low_id_for_home(IDX_W'(0));
    hot_low[3] = low_id_for_home(IDX_W'(1));
    hot_low[4] = low_id_for_home(IDX_W'(spot));
    hot_low[5] = low_id_for_home(IDX_W'(spot + 2));
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        wait_for_quiet();
      end
      if (k < count - CALM_TAIL && (k / 100) % 4 != 3 && $urandom_range(0, 7) == 0) begin
        pause($urandom_range(1, 15));
      end
      issue(random_item());
    end
  endtask

  // Every result strobe must match the oldest answer owed; the block cannot
  // be stalled, so the check runs on every edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (answers_due.size() == 0) begin
        $error("result with no transaction outstanding: hit %0b evicted %0b",
               rsp_o.hit, rsp_o.evicted);
        errors++;
      end else begin
        oldest_answer = answers_due.pop_front();
        if (rsp_o.hit !== oldest_answer.hit) begin
          $error("hit: expected %0b, got %0b", oldest_answer.hit, rsp_o.hit);
          errors++;
        end
        if (rsp_o.evicted !== oldest_answer.evicted) begin
          $error("evicted: expected %0b, got %0b", oldest_answer.evicted, rsp_o.evicted);
          errors++;
        end
      end
    end
  end

  // Watchdog against a block that stops answering or never drops busy.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // The store starts empty, matching the clearing sweep the block runs
    // after reset; the first transaction waits for busy to drop.
    for (int k = 0; k < SLOTS; k++) begin
      shadow_pid[k]  = '0;
      shadow_time[k] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_mark_and_lookup();
    test_probe_chain();
    test_wrap_and_zero_id();
    test_clear_all();
    test_random_traffic(RANDOM_ITEMS);

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bpdt_pkg.sv
sv/bpdt_ram.sv
sv/bpdt_hash.sv
sv/bounded_probe_dedup_table.sv
tb/sv/bounded_probe_dedup_table_test.sv
